[rtl/pa2d_pkg.sv]
// ============================================================================
// pa2d_pkg - shared types and constants for the polynomial atan2 block
// Holds the fixed-point formats, the degree-scaled polynomial coefficients,
// the side-band word that rides along the divider, and the rounding helper.
// ============================================================================
package pa2d_pkg;

  // Ratio of the smaller to the larger magnitude, unsigned Q1.16.
  localparam int RATIO_BITS = 16;
  localparam int RATIO_W    = RATIO_BITS + 1;
  // One restoring step per quotient bit, from bit 16 down to bit 0.
  localparam int DIV_STAGES = RATIO_BITS + 1;

  // Internal angles carry 16 fraction bits of a degree.
  localparam int ANG_FRAC = 16;
  // Horner accumulator, product and reflected angle widths.
  localparam int ACC_W  = 24;
  localparam int PROD_W = ACC_W + RATIO_W + 1;
  localparam int ANG_W  = 26;

  // Coefficients of the odd polynomial in units of 2^-16 degree.
  localparam logic signed [ACC_W-1:0] COEF_P1 =  24'sd3754140;
  localparam logic signed [ACC_W-1:0] COEF_P3 = -24'sd1223390;
  localparam logic signed [ACC_W-1:0] COEF_P5 =  24'sd584188;
  localparam logic signed [ACC_W-1:0] COEF_P7 = -24'sd166443;

  localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;

  // Octant and quadrant information that follows a word down the pipe.
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic steep;
    logic zero;
  } pa2d_side_t;

  // Arithmetic shift right by s, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic signed [63:0] half;
    half = (s == 0) ? 64'sd0 : (64'sd1 <<< (s - 1));
    if (s == 0) begin
      rnd_shift = v;
    end else if (v < 0) begin
      rnd_shift = (v + half - 64'sd1) >>> s;
    end else begin
      rnd_shift = (v + half) >>> s;
    end
  endfunction

endpackage

[rtl/pa2d_div.sv]
// ============================================================================
// pa2d_div - pipelined restoring divider for the octant ratio
// Forms floor(num * 2^16 / den) for num <= den, one quotient bit per stage,
// and carries the side-band word along with each quotient.
// ============================================================================
module pa2d_div #(
  parameter int INPUT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_stall,
  input  logic [INPUT_WIDTH-1:0]              up_num,
  input  logic [INPUT_WIDTH-1:0]              up_den,
  input  pa2d_pkg::pa2d_side_t                up_side,
  output logic                                dn_valid,
  input  logic                                dn_stall,
  output logic [pa2d_pkg::RATIO_W-1:0]        dn_quot,
  output pa2d_pkg::pa2d_side_t                dn_side
);
  import pa2d_pkg::*;

  localparam int W = INPUT_WIDTH;

  logic [DIV_STAGES-1:0] vld_r;
  logic [DIV_STAGES:0]   rdy;
  logic [W-1:0]          rem_r  [DIV_STAGES];
  logic [W-1:0]          den_r  [DIV_STAGES];
  logic [RATIO_W-1:0]    quo_r  [DIV_STAGES];
  pa2d_side_t            side_r [DIV_STAGES];

  logic [W:0]            src_rem  [DIV_STAGES];
  logic [W-1:0]          src_den  [DIV_STAGES];
  logic [RATIO_W-1:0]    src_quo  [DIV_STAGES];
  pa2d_side_t            src_side [DIV_STAGES];
  logic [DIV_STAGES-1:0] src_vld;
  logic [W:0]            diff     [DIV_STAGES];
  logic [DIV_STAGES-1:0] sub_ok;

  // Each stage compares the partial remainder with the divisor; the first
  // stage sees the numerator unshifted, the rest see the remainder doubled.
  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        src_rem[i]  = {1'b0, up_num};
        src_den[i]  = up_den;
        src_quo[i]  = '0;
        src_side[i] = up_side;
        src_vld[i]  = up_valid;
      end else begin
        src_rem[i]  = {rem_r[i-1], 1'b0};
        src_den[i]  = den_r[i-1];
        src_quo[i]  = quo_r[i-1];
        src_side[i] = side_r[i-1];
        src_vld[i]  = vld_r[i-1];
      end
      sub_ok[i] = src_rem[i] >= {1'b0, src_den[i]};
      diff[i]   = src_rem[i] - {1'b0, src_den[i]};
    end
  end

  // A stage may load when it is empty or its successor moves.
  always_comb begin
    rdy[DIV_STAGES] = !dn_stall;
    for (int i = DIV_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_r[i] <= src_vld[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (rdy[i]) begin
        rem_r[i]  <= sub_ok[i] ? diff[i][W-1:0] : src_rem[i][W-1:0];
        den_r[i]  <= src_den[i];
        quo_r[i]  <= {src_quo[i][RATIO_W-2:0], sub_ok[i]};
        side_r[i] <= src_side[i];
      end
    end
  end

  assign up_stall = !rdy[0];
  assign dn_valid = vld_r[DIV_STAGES-1];
  assign dn_quot  = quo_r[DIV_STAGES-1];
  assign dn_side  = side_r[DIV_STAGES-1];

endmodule

[rtl/polynomial_atan2_degrees.sv]
// ============================================================================
// polynomial_atan2_degrees - four-quadrant arctangent in degrees
// Folds (x, y) into the first octant, divides the smaller magnitude by the
// larger, evaluates a 7th-order odd polynomial and unfolds the octant.
// ============================================================================
//
//   Channel  Ports                                    Word
//   -------  ---------------------------------------  ---------------------------
//   input    in_valid, in_stall, in_x/y_component     one signed (x, y) pair
//   result   out_valid, out_stall, out_angle_degrees  one angle, 1/2^F degree
//
// A new word can enter on every clock cycle, and one angle leaves per cycle
// in steady state, while neither side stalls. The pipe has one fold stage,
// 17 divider stages (one quotient bit each), one squaring stage, four
// Horner multiply stages, two reflection stages and the output register.
// Reset is synchronous and active low; it clears only the valid bits.
// Each stage holds its word while the next stage is full and stalled, so
// empty stages still fill while a finished angle waits at the output.
//
module polynomial_atan2_degrees #(
  parameter int INPUT_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [INPUT_WIDTH-1:0]     in_x_component,
  input  logic signed [INPUT_WIDTH-1:0]     in_y_component,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ANGLE_FRAC_BITS+8:0] out_angle_degrees
);
  import pa2d_pkg::*;

  localparam int W         = INPUT_WIDTH;
  // Sign, eight integer bits for 180 and the fraction bits.
  localparam int OUT_W     = ANGLE_FRAC_BITS + 9;
  localparam int OUT_SHIFT = ANG_FRAC - ANGLE_FRAC_BITS;

  // --------------------------------------------------------------------------
  // Ready chain: a stage loads when it is empty or the stage after it moves.
  // --------------------------------------------------------------------------
  logic fd_vld_r, sq_vld_r, h7_vld_r, h5_vld_r, h3_vld_r, h1_vld_r;
  logic rf_vld_r, sg_vld_r, out_vld_r;
  logic rdy_fd, rdy_sq, rdy_h7, rdy_h5, rdy_h3, rdy_h1, rdy_rf, rdy_sg, rdy_out;
  logic div_stall, dv_valid;

  assign rdy_out = !out_vld_r || !out_stall;
  assign rdy_sg  = !sg_vld_r  || rdy_out;
  assign rdy_rf  = !rf_vld_r  || rdy_sg;
  assign rdy_h1  = !h1_vld_r  || rdy_rf;
  assign rdy_h3  = !h3_vld_r  || rdy_h1;
  assign rdy_h5  = !h5_vld_r  || rdy_h3;
  assign rdy_h7  = !h7_vld_r  || rdy_h5;
  assign rdy_sq  = !sq_vld_r  || rdy_h7;
  assign rdy_fd  = !fd_vld_r  || !div_stall;

  assign in_stall = !rdy_fd;

  // --------------------------------------------------------------------------
  // Fold: magnitudes, signs and the octant choice. The most negative input
  // has magnitude 2^(W-1), which the unsigned W-bit negation gives exactly.
  // --------------------------------------------------------------------------
  logic [W-1:0] ax, ay, fd_mn_nxt, fd_mx_nxt, fd_mn_r, fd_mx_r;
  pa2d_side_t   fd_side_nxt, fd_side_r;

  always_comb begin
    ax = in_x_component[W-1] ? (~in_x_component + 1'b1) : in_x_component;
    ay = in_y_component[W-1] ? (~in_y_component + 1'b1) : in_y_component;
    fd_side_nxt.x_neg = in_x_component[W-1];
    fd_side_nxt.y_neg = in_y_component[W-1];
    fd_side_nxt.steep = ay > ax;
    fd_mn_nxt = fd_side_nxt.steep ? ax : ay;
    fd_mx_nxt = fd_side_nxt.steep ? ay : ax;
    // Both magnitudes zero: the ratio is forced to zero after the divider.
    fd_side_nxt.zero = (fd_mx_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_vld_r <= 1'b0;
    end else if (rdy_fd) begin
      fd_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_fd) begin
      fd_mn_r   <= fd_mn_nxt;
      fd_mx_r   <= fd_mx_nxt;
      fd_side_r <= fd_side_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Ratio c = floor(min * 2^16 / max), Q1.16.
  // --------------------------------------------------------------------------
  logic [RATIO_W-1:0] dv_quot;
  pa2d_side_t         dv_side;

  pa2d_div #(
    .INPUT_WIDTH(INPUT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fd_vld_r),
    .up_stall (div_stall),
    .up_num   (fd_mn_r),
    .up_den   (fd_mx_r),
    .up_side  (fd_side_r),
    .dn_valid (dv_valid),
    .dn_stall (!rdy_sq),
    .dn_quot  (dv_quot),
    .dn_side  (dv_side)
  );

  // --------------------------------------------------------------------------
  // Square of the ratio, kept at full width for rounding in the next stage.
  // --------------------------------------------------------------------------
  logic [RATIO_W-1:0]   sq_c_nxt, sq_c_r;
  logic [2*RATIO_W-1:0] sq_p_nxt, sq_p_r;
  pa2d_side_t           sq_side_r;

  always_comb begin
    sq_c_nxt = dv_side.zero ? '0 : dv_quot;
    sq_p_nxt = sq_c_nxt * sq_c_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (rdy_sq) begin
      sq_vld_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_sq) begin
      sq_c_r    <= sq_c_nxt;
      sq_p_r    <= sq_p_nxt;
      sq_side_r <= dv_side;
    end
  end

  // --------------------------------------------------------------------------
  // Horner evaluation in c^2, one multiply per stage:
  //   t = p7; t = t*c2 + p5; t = t*c2 + p3; t = t*c2 + p1; a = t*c.
  // Every product is rounded back to 16 fraction bits in the stage after it.
  // --------------------------------------------------------------------------
  logic [RATIO_W-1:0]       c2_nxt;
  logic [RATIO_W-1:0]       h7_c_r, h7_c2_r, h5_c_r, h5_c2_r, h3_c_r;
  logic signed [PROD_W-1:0] h7_p_nxt, h5_p_nxt, h3_p_nxt, h1_p_nxt;
  logic signed [PROD_W-1:0] h7_p_r, h5_p_r, h3_p_r, h1_p_r;
  logic signed [ACC_W-1:0]  t5, t3, t1;
  pa2d_side_t               h7_side_r, h5_side_r, h3_side_r, h1_side_r;

  always_comb begin
    c2_nxt   = RATIO_W'(rnd_shift(64'(sq_p_r), RATIO_BITS));
    h7_p_nxt = COEF_P7 * $signed({1'b0, c2_nxt});
    t5       = ACC_W'(rnd_shift(64'(h7_p_r), RATIO_BITS)) + COEF_P5;
    h5_p_nxt = t5 * $signed({1'b0, h7_c2_r});
    t3       = ACC_W'(rnd_shift(64'(h5_p_r), RATIO_BITS)) + COEF_P3;
    h3_p_nxt = t3 * $signed({1'b0, h5_c2_r});
    t1       = ACC_W'(rnd_shift(64'(h3_p_r), RATIO_BITS)) + COEF_P1;
    h1_p_nxt = t1 * $signed({1'b0, h3_c_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h7_vld_r <= 1'b0;
      h5_vld_r <= 1'b0;
      h3_vld_r <= 1'b0;
      h1_vld_r <= 1'b0;
    end else begin
      if (rdy_h7) begin
        h7_vld_r <= sq_vld_r;
      end
      if (rdy_h5) begin
        h5_vld_r <= h7_vld_r;
      end
      if (rdy_h3) begin
        h3_vld_r <= h5_vld_r;
      end
      if (rdy_h1) begin
        h1_vld_r <= h3_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_h7) begin
      h7_c_r    <= sq_c_r;
      h7_c2_r   <= c2_nxt;
      h7_p_r    <= h7_p_nxt;
      h7_side_r <= sq_side_r;
    end
    if (rdy_h5) begin
      h5_c_r    <= h7_c_r;
      h5_c2_r   <= h7_c2_r;
      h5_p_r    <= h5_p_nxt;
      h5_side_r <= h7_side_r;
    end
    if (rdy_h3) begin
      h3_c_r    <= h5_c_r;
      h3_p_r    <= h3_p_nxt;
      h3_side_r <= h5_side_r;
    end
    if (rdy_h1) begin
      h1_p_r    <= h1_p_nxt;
      h1_side_r <= h3_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // Unfold: reflect about 90 for steep vectors, then 180 minus the angle for
  // negative x, then negate for negative y. Zero y with negative x thus
  // yields +180.
  // --------------------------------------------------------------------------
  logic signed [ANG_W-1:0] oct_a, rf_a_nxt, rf_a_r, sg_b, sg_a_nxt, sg_a_r;
  pa2d_side_t              rf_side_r;

  always_comb begin
    oct_a    = ANG_W'(rnd_shift(64'(h1_p_r), RATIO_BITS));
    rf_a_nxt = h1_side_r.steep ? (DEG90 - oct_a) : oct_a;
    sg_b     = rf_side_r.x_neg ? (DEG180 - rf_a_r) : rf_a_r;
    sg_a_nxt = rf_side_r.y_neg ? -sg_b : sg_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= 1'b0;
      sg_vld_r <= 1'b0;
    end else begin
      if (rdy_rf) begin
        rf_vld_r <= h1_vld_r;
      end
      if (rdy_sg) begin
        sg_vld_r <= rf_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_rf) begin
      rf_a_r    <= rf_a_nxt;
      rf_side_r <= h1_side_r;
    end
    if (rdy_sg) begin
      sg_a_r <= sg_a_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: round from 16 fraction bits to ANGLE_FRAC_BITS.
  // --------------------------------------------------------------------------
  logic signed [OUT_W-1:0] out_a_nxt, out_a_r;

  assign out_a_nxt = OUT_W'(rnd_shift(64'(sg_a_r), OUT_SHIFT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rdy_out) begin
      out_vld_r <= sg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_a_r <= out_a_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_angle_degrees = out_a_r;

endmodule

[rtl/pa2d_chk.sv]
// ============================================================================
// pa2d_chk - port-level checks for the polynomial atan2 block
// Watches the two channels of the top level and is attached to it by bind.
// ============================================================================
module pa2d_chk #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [ANGLE_FRAC_BITS+8:0] out_angle_degrees
);

  localparam int OUT_W = ANGLE_FRAC_BITS + 9;
  localparam logic signed [OUT_W-1:0] LIM = OUT_W'(180 << ANGLE_FRAC_BITS);

  // A held result keeps its valid and its angle.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_angle_degrees))
    else $error("result word changed while stalled");

  // Every delivered angle lies within -180 to +180 degrees.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_degrees <= LIM) && (out_angle_degrees >= -LIM))
    else $error("angle outside -180..180");

  // The input side only backs up when the whole pipe is full behind a
  // stalled result.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side is free");

  // With the result side free, the input is never stalled.
  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with no backpressure");

endmodule

bind polynomial_atan2_degrees pa2d_chk #(
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_pa2d_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_angle_degrees (out_angle_degrees)
);
